// ===== src/frc_pkg.sv =====
`timescale 1ns / 1ps

package frc_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hEF;
  localparam logic [7:0] HDR_SECOND = 8'h01;
  localparam logic [7:0] REPLY_PID  = 8'h07;
  localparam logic [7:0] ADDR_BYTES = 8'd4;
  localparam logic [7:0] MIN_LENGTH = 8'd3;
  localparam logic [7:0] CKSUM_BYTES = 8'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_CODE_SUCCESS     = 8'd0;
  localparam logic [7:0] CFG_CODE_NO_FINGER   = 8'd1;
  localparam logic [7:0] CFG_CODE_LOW_QUALITY = 8'd2;
  localparam logic [7:0] CFG_CODE_NOT_FOUND   = 8'd3;

  localparam logic [7:0] RST_CODE_SUCCESS     = 8'd0;
  localparam logic [7:0] RST_CODE_NO_FINGER   = 8'd2;
  localparam logic [7:0] RST_CODE_LOW_QUALITY = 8'd7;
  localparam logic [7:0] RST_CODE_NOT_FOUND   = 8'd9;

  typedef enum logic [3:0] {
    PH_HUNT1 = 4'd0,
    PH_HUNT2 = 4'd1,
    PH_ADDR  = 4'd2,
    PH_PID   = 4'd3,
    PH_LENHI = 4'd4,
    PH_LENLO = 4'd5,
    PH_BODY  = 4'd6,
    PH_CKHI  = 4'd7,
    PH_CKLO  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_POOR      = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_OTHER     = 3'd3,
    ST_FRAMEERR  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] success;
    logic [7:0] no_finger;
    logic [7:0] low_quality;
    logic [7:0] not_found;
  } code_cfg_t;

  // Event raised by the parser when a frame ends or fails.
  typedef struct packed {
    logic       valid;
    logic       frame_err;
    logic [7:0] code;
  } frame_evt_t;

endpackage

// ===== src/finger_reply_frame_checker.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_rx_byte[7:0]
// out_      output     out_valid / out_ready out_status[2:0], out_confirm_code[7:0]
// cfg_      input      cfg_valid / cfg_ready cfg_index[7:0], cfg_data[7:0]
//
// Each item passes an input register, then the frame parser and code classifier,
// then the result register, which drives the out_ channel.
// One item is taken per cycle as long as the result register drains, so the
// sustained rate is one byte per clock, set by the parser step.
// Reset (synchronous, active low) clears both stage valids, the parser state and
// the confirm code registers to their defaults. A stalled result holds the input
// register; in_ready drops only while both stages hold an item.

module finger_reply_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_confirm_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Input stage register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Result register.
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [7:0] out_confirm_code_r;

  frc_pkg::code_cfg_t  codes_r;
  frc_pkg::frame_evt_t evt;
  frc_pkg::status_t    status;
  logic                advance;
  logic                out_free;

  // The result slot is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ready;
  // The parser consumes the staged byte only when a possible result has room.
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || advance;

  // Configuration is always writable; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.success     <= frc_pkg::RST_CODE_SUCCESS;
      codes_r.no_finger   <= frc_pkg::RST_CODE_NO_FINGER;
      codes_r.low_quality <= frc_pkg::RST_CODE_LOW_QUALITY;
      codes_r.not_found   <= frc_pkg::RST_CODE_NOT_FOUND;
    end else if (cfg_valid) begin
      case (cfg_index)
        frc_pkg::CFG_CODE_SUCCESS:     codes_r.success     <= cfg_data;
        frc_pkg::CFG_CODE_NO_FINGER:   codes_r.no_finger   <= cfg_data;
        frc_pkg::CFG_CODE_LOW_QUALITY: codes_r.low_quality <= cfg_data;
        frc_pkg::CFG_CODE_NOT_FOUND:   codes_r.not_found   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; the byte is loaded whenever the stage accepts a new item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  frc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (s1_byte_r),
    .evt     (evt)
  );

  frc_classify u_classify (
    .evt    (evt),
    .codes  (codes_r),
    .status (status)
  );

  // Result register: filled when the parser reports a frame end or failure.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.valid) begin
      out_status_r       <= status;
      out_confirm_code_r <= evt.code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_confirm_code = out_confirm_code_r;

endmodule

// ===== src/frc_parser.sv =====
`timescale 1ns / 1ps

module frc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output frc_pkg::frame_evt_t evt
);

  frc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  body_length_r, body_length_nxt;
  logic [7:0]  held_code_r, held_code_nxt;
  logic [7:0]  checksum_high_r, checksum_high_nxt;
  logic [7:0]  count_inc;
  logic [15:0] sum_add;

  assign count_inc = byte_count_r + 8'd1;
  assign sum_add   = running_sum_r + {8'd0, rx_byte};

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    body_length_nxt   = body_length_r;
    held_code_nxt     = held_code_r;
    checksum_high_nxt = checksum_high_r;
    evt               = '0;
    case (phase_r)
      frc_pkg::PH_HUNT2: begin
        if (rx_byte == frc_pkg::HDR_SECOND) begin
          phase_nxt      = frc_pkg::PH_ADDR;
          byte_count_nxt = 8'd0;
        end else if (rx_byte != frc_pkg::HDR_FIRST) begin
          phase_nxt = frc_pkg::PH_HUNT1;
        end
      end
      frc_pkg::PH_ADDR: begin
        if (count_inc >= frc_pkg::ADDR_BYTES) begin
          byte_count_nxt = 8'd0;
          phase_nxt      = frc_pkg::PH_PID;
        end else begin
          byte_count_nxt = count_inc;
        end
      end
      frc_pkg::PH_PID: begin
        if (rx_byte != frc_pkg::REPLY_PID) begin
          evt.valid      = 1'b1;
          evt.frame_err  = 1'b1;
          phase_nxt      = frc_pkg::PH_HUNT1;
          byte_count_nxt = 8'd0;
        end else begin
          running_sum_nxt = {8'd0, rx_byte};
          phase_nxt       = frc_pkg::PH_LENHI;
        end
      end
      frc_pkg::PH_LENHI: begin
        running_sum_nxt = sum_add;
        phase_nxt       = frc_pkg::PH_LENLO;
      end
      frc_pkg::PH_LENLO: begin
        running_sum_nxt = sum_add;
        body_length_nxt = rx_byte;
        byte_count_nxt  = 8'd0;
        if (rx_byte < frc_pkg::MIN_LENGTH) begin
          evt.valid     = 1'b1;
          evt.frame_err = 1'b1;
          phase_nxt     = frc_pkg::PH_HUNT1;
        end else begin
          phase_nxt = frc_pkg::PH_BODY;
        end
      end
      frc_pkg::PH_BODY: begin
        if (byte_count_r == 8'd0) begin
          held_code_nxt = rx_byte;
        end
        running_sum_nxt = sum_add;
        byte_count_nxt  = count_inc;
        // The body length counts the two checksum bytes as well.
        if (count_inc >= body_length_r - frc_pkg::CKSUM_BYTES) begin
          phase_nxt = frc_pkg::PH_CKHI;
        end
      end
      frc_pkg::PH_CKHI: begin
        checksum_high_nxt = rx_byte;
        phase_nxt         = frc_pkg::PH_CKLO;
      end
      frc_pkg::PH_CKLO: begin
        evt.valid      = 1'b1;
        phase_nxt      = frc_pkg::PH_HUNT1;
        byte_count_nxt = 8'd0;
        if (checksum_high_r != running_sum_r[15:8] || rx_byte != running_sum_r[7:0]) begin
          evt.frame_err = 1'b1;
        end else begin
          evt.code = held_code_r;
        end
      end
      default: begin
        if (rx_byte == frc_pkg::HDR_FIRST) begin
          phase_nxt = frc_pkg::PH_HUNT2;
        end else begin
          phase_nxt = frc_pkg::PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= frc_pkg::PH_HUNT1;
      byte_count_r    <= 8'd0;
      running_sum_r   <= 16'd0;
      body_length_r   <= 8'd0;
      held_code_r     <= 8'd0;
      checksum_high_r <= 8'd0;
    end else if (advance) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      body_length_r   <= body_length_nxt;
      held_code_r     <= held_code_nxt;
      checksum_high_r <= checksum_high_nxt;
    end
  end

endmodule

// ===== src/frc_classify.sv =====
`timescale 1ns / 1ps

module frc_classify (
  input  frc_pkg::frame_evt_t evt,
  input  frc_pkg::code_cfg_t  codes,
  output frc_pkg::status_t    status
);

  // A frame error takes priority; otherwise the first match wins, in the order success, poor image, not found.
  always_comb begin
    if (evt.frame_err) begin
      status = frc_pkg::ST_FRAMEERR;
    end else if (evt.code == codes.success) begin
      status = frc_pkg::ST_OK;
    end else if (evt.code == codes.no_finger || evt.code == codes.low_quality) begin
      status = frc_pkg::ST_POOR;
    end else if (evt.code == codes.not_found) begin
      status = frc_pkg::ST_NOTFOUND;
    end else begin
      status = frc_pkg::ST_OTHER;
    end
  end

endmodule
